// ----- sv/rpn3_pkg.sv -----
`timescale 1ns / 1ps
// Package for the three-level RPN calculator: widths, character codes,
// micro-operation codes, the control word and the microcode ROM.
// Depends on nothing; used by the core and by its checker.
package rpn3_pkg;

    localparam int DATA_W = 64;
    localparam int STEP_W = $clog2(DATA_W);
    localparam int UPC_W  = 4;
    localparam int CHAR_W = 8;

    typedef logic [UPC_W-1:0]  upc_t;
    typedef logic [DATA_W-1:0] word_t;
    typedef logic [CHAR_W-1:0] char_t;

    localparam char_t CH_ZERO  = 8'h30;
    localparam char_t CH_NINE  = 8'h39;
    localparam char_t CH_PLUS  = 8'h2B;
    localparam char_t CH_MINUS = 8'h2D;
    localparam char_t CH_STAR  = 8'h2A;
    localparam char_t CH_SLASH = 8'h2F;
    localparam char_t CH_CR    = 8'h0D;
    localparam char_t CH_LF    = 8'h0A;

    // Microcode addresses.
    localparam upc_t A_IDLE = 4'd0;
    localparam upc_t A_DIG1 = 4'd1;
    localparam upc_t A_DIG2 = 4'd2;
    localparam upc_t A_ADD  = 4'd3;
    localparam upc_t A_SUB  = 4'd4;
    localparam upc_t A_MULI = 4'd5;
    localparam upc_t A_MULS = 4'd6;
    localparam upc_t A_MULE = 4'd7;
    localparam upc_t A_DIVI = 4'd8;
    localparam upc_t A_DIVS = 4'd9;
    localparam upc_t A_DIVE = 4'd10;
    localparam upc_t A_PUSH = 4'd11;
    localparam upc_t A_FIN  = 4'd12;

    typedef enum logic [3:0] {
        U_NOP,
        U_DIG1,
        U_DIG2,
        U_ADD,
        U_SUB,
        U_MULI,
        U_MULS,
        U_MULE,
        U_DIVI,
        U_DIVS,
        U_DIVE,
        U_PUSH,
        U_OUT
    } uop_t;

    typedef enum logic [2:0] {
        BR_NEXT,
        BR_GOTO,
        BR_LOOP,
        BR_XZERO,
        BR_DISPATCH,
        BR_OUT
    } br_t;

    typedef struct packed {
        uop_t op;
        br_t  br;
        upc_t target;
    } uword_t;

    // Entry point of the routine for one character.
    function automatic upc_t entry_of(char_t c);
        upc_t a;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            a = A_DIG1;
        end
        else
        begin
            case (c)
                CH_PLUS:  a = A_ADD;
                CH_MINUS: a = A_SUB;
                CH_STAR:  a = A_MULI;
                CH_SLASH: a = A_DIVI;
                CH_CR:    a = A_PUSH;
                CH_LF:    a = A_PUSH;
                default:  a = A_FIN;
            endcase
        end
        return a;
    endfunction

    // The control program.
    function automatic uword_t ucode(upc_t a);
        uword_t w;
        case (a)
            A_IDLE:  w = '{op: U_NOP,  br: BR_DISPATCH, target: A_IDLE};
            A_DIG1:  w = '{op: U_DIG1, br: BR_NEXT,     target: A_DIG2};
            A_DIG2:  w = '{op: U_DIG2, br: BR_GOTO,     target: A_FIN};
            A_ADD:   w = '{op: U_ADD,  br: BR_GOTO,     target: A_FIN};
            A_SUB:   w = '{op: U_SUB,  br: BR_GOTO,     target: A_FIN};
            A_MULI:  w = '{op: U_MULI, br: BR_NEXT,     target: A_MULS};
            A_MULS:  w = '{op: U_MULS, br: BR_LOOP,     target: A_MULS};
            A_MULE:  w = '{op: U_MULE, br: BR_GOTO,     target: A_FIN};
            A_DIVI:  w = '{op: U_DIVI, br: BR_XZERO,    target: A_FIN};
            A_DIVS:  w = '{op: U_DIVS, br: BR_LOOP,     target: A_DIVS};
            A_DIVE:  w = '{op: U_DIVE, br: BR_GOTO,     target: A_FIN};
            A_PUSH:  w = '{op: U_PUSH, br: BR_GOTO,     target: A_FIN};
            A_FIN:   w = '{op: U_OUT,  br: BR_OUT,      target: A_IDLE};
            default: w = '{op: U_NOP,  br: BR_GOTO,     target: A_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- sv/rpn_three_level_calculator_core.sv -----
`timescale 1ns / 1ps
// Three-level RPN calculator core: microcode sequencer and 64-bit datapath.
// Depends on rpn3_pkg for the control word, the character codes and the ROM.

// One character is taken per input beat and one result beat, carrying the
// three stack levels X, Y and Z and a divide-by-zero flag, follows for every
// character. The block works on one character at a time: in_ready is high
// only while the sequencer sits at its idle step. A digit passes the steps
// DIG1 and DIG2, an add, subtract or push its own step, and an ignored
// character goes straight to the final output step. A multiply or a divide
// runs a shift-and-add or a restoring divide step one bit per cycle through
// all 64 bits; a divide by zero skips the loop. The result is held in an
// output register, so the block returns to idle and takes the next character
// while a previous result beat still waits; it only stalls at its final step
// when a new result is ready and the old one has not yet been taken. Digits
// shift into X as X*10+d; sums, differences, products and digit entry wrap
// modulo 2^64; division truncates toward zero, and a divide by zero leaves X
// at zero and raises the flag for that beat only.
module rpn_three_level_calculator_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rpn3_pkg::char_t      char_code,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [63:0]   reg_x,
    output logic signed [63:0]   reg_y,
    output logic signed [63:0]   reg_z,
    output logic                 divide_by_zero
);
    import rpn3_pkg::*;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

    // Sequencer state.
    upc_t              upc_reg, upc_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;

    // Stack and working registers.
    word_t x_reg, x_next;
    word_t y_reg, y_next;
    word_t z_reg, z_next;
    word_t a_reg, a_next;    // product accumulator, remainder, digit scratch
    word_t q_reg, q_next;    // multiplier, then quotient
    word_t d_reg, d_next;    // multiplicand, then divisor
    logic  neg_reg, neg_next;
    logic  flag_reg, flag_next;
    char_t char_reg, char_next;

    // Result register.
    word_t out_x_reg, out_x_next;
    word_t out_y_reg, out_y_next;
    word_t out_z_reg, out_z_next;
    logic  out_f_reg, out_f_next;

    uword_t         uw;
    logic           accept;
    logic           slot_free;
    logic           x_zero;
    word_t          div_shift;
    logic [DATA_W:0] div_trial;

    always_comb
    begin
        uw = ucode(upc_reg);
    end

    assign in_ready  = (upc_reg == A_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign x_zero    = (x_reg == '0);

    // Restoring divide: shift the next dividend bit into the remainder and
    // try to take the divisor away.
    assign div_shift = {a_reg[DATA_W-2:0], q_reg[DATA_W-1]};
    assign div_trial = {1'b0, div_shift} - {1'b0, d_reg};

    // Step counter and jump logic.
    always_comb
    begin
        upc_next = upc_reg + upc_t'(1);
        case (uw.br)
            BR_NEXT:     upc_next = upc_reg + upc_t'(1);
            BR_GOTO:     upc_next = uw.target;
            BR_LOOP:     upc_next = (cnt_reg != LAST_STEP) ? uw.target
                                                           : upc_reg + upc_t'(1);
            BR_XZERO:    upc_next = x_zero ? uw.target : upc_reg + upc_t'(1);
            BR_DISPATCH: upc_next = in_valid ? entry_of(char_code) : upc_reg;
            BR_OUT:      upc_next = slot_free ? uw.target : upc_reg;
            default:     upc_next = A_IDLE;
        endcase
    end

    // Datapath controlled by the current micro-operation.
    always_comb
    begin
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        a_next         = a_reg;
        q_next         = q_reg;
        d_next         = d_reg;
        neg_next       = neg_reg;
        flag_next      = flag_reg;
        char_next      = char_reg;
        cnt_next       = cnt_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_z_next     = out_z_reg;
        out_f_next     = out_f_reg;
        out_valid_next = out_valid_reg && !out_ready;

        case (uw.op)
            U_NOP:
            begin
                if (accept)
                begin
                    char_next = char_code;
                    flag_next = 1'b0;
                end
            end
            U_DIG1:
            begin
                // The low nibble of an ASCII digit is its value.
                a_next = (x_reg << 3) + {{(DATA_W-4){1'b0}}, char_reg[3:0]};
            end
            U_DIG2:
            begin
                x_next = a_reg + (x_reg << 1);
            end
            U_ADD:
            begin
                x_next = x_reg + y_reg;
            end
            U_SUB:
            begin
                x_next = y_reg - x_reg;
            end
            U_MULI:
            begin
                a_next   = '0;
                q_next   = x_reg;
                d_next   = y_reg;
                cnt_next = '0;
            end
            U_MULS:
            begin
                a_next   = q_reg[0] ? a_reg + d_reg : a_reg;
                d_next   = d_reg << 1;
                q_next   = q_reg >> 1;
                cnt_next = cnt_reg + 1'b1;
            end
            U_MULE:
            begin
                x_next = a_reg;
            end
            U_DIVI:
            begin
                // Work on magnitudes; the sign is put back at the end.
                a_next    = '0;
                q_next    = y_reg[DATA_W-1] ? '0 - y_reg : y_reg;
                d_next    = x_reg[DATA_W-1] ? '0 - x_reg : x_reg;
                neg_next  = y_reg[DATA_W-1] ^ x_reg[DATA_W-1];
                flag_next = x_zero;
                cnt_next  = '0;
            end
            U_DIVS:
            begin
                if (!div_trial[DATA_W])
                begin
                    a_next = div_trial[DATA_W-1:0];
                    q_next = {q_reg[DATA_W-2:0], 1'b1};
                end
                else
                begin
                    a_next = div_shift;
                    q_next = {q_reg[DATA_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
            end
            U_DIVE:
            begin
                x_next = neg_reg ? '0 - q_reg : q_reg;
            end
            U_PUSH:
            begin
                z_next = y_reg;
                y_next = x_reg;
                x_next = '0;
            end
            U_OUT:
            begin
                if (slot_free)
                begin
                    out_x_next     = x_reg;
                    out_y_next     = y_reg;
                    out_z_next     = z_reg;
                    out_f_next     = flag_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                x_next = x_reg;
            end
        endcase
    end

    // Control state and the stack, which the model clears at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= A_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            x_reg         <= '0;
            y_reg         <= '0;
            z_reg         <= '0;
            flag_reg      <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            z_reg         <= z_next;
            flag_reg      <= flag_next;
        end
    end

    // Working and result payload registers need no reset.
    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        q_reg     <= q_next;
        d_reg     <= d_next;
        neg_reg   <= neg_next;
        char_reg  <= char_next;
        out_x_reg <= out_x_next;
        out_y_reg <= out_y_next;
        out_z_reg <= out_z_next;
        out_f_reg <= out_f_next;
    end

    assign out_valid      = out_valid_reg;
    assign reg_x          = $signed(out_x_reg);
    assign reg_y          = $signed(out_y_reg);
    assign reg_z          = $signed(out_z_reg);
    assign divide_by_zero = out_f_reg;

endmodule

// ----- sv/rpn3_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the three-level RPN calculator core and its bind.
// Depends on rpn3_pkg and on rpn_three_level_calculator_core.
module rpn3_checker
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input rpn3_pkg::char_t      char_code,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic signed [63:0]   reg_x,
    input logic signed [63:0]   reg_y,
    input logic signed [63:0]   reg_z,
    input logic                 divide_by_zero
);
    import rpn3_pkg::*;

    // A waiting character beat keeps its code until it is taken.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(char_code))
        else $error("character beat changed while waiting");

    // A result beat held back by the sink keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(reg_x)
            && $stable(reg_y) && $stable(reg_z) && $stable(divide_by_zero))
        else $error("result beat changed while stalled");

    // Only one character is in work at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while busy");

    // Returning to idle always comes with a result beat on offer.
    a_ready_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_ready) |-> out_valid)
        else $error("returned to idle without a result");

    // A divide by zero leaves X at zero.
    a_dbz_x: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_by_zero |-> reg_x == 64'sd0)
        else $error("divide by zero with nonzero X");

endmodule

bind rpn_three_level_calculator_core rpn3_checker u_rpn3_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .char_code      (char_code),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .reg_x          (reg_x),
    .reg_y          (reg_y),
    .reg_z          (reg_z),
    .divide_by_zero (divide_by_zero)
);
